/* src/tcmb_pkg.sv */
`timescale 1ns / 1ps

package tcmb_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 128;
  localparam int COL_LIM  = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int ROW_LIM  = (MAX_ROWS < 128) ? MAX_ROWS : 128;

  localparam int CFG_ADDR_W  = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] REQ_MOVE_TO = 3'd0;
  localparam logic [2:0] REQ_LEFT    = 3'd1;
  localparam logic [2:0] REQ_RIGHT   = 3'd2;
  localparam logic [2:0] REQ_UP      = 3'd3;
  localparam logic [2:0] REQ_DOWN    = 3'd4;
  localparam logic [2:0] REQ_TICK    = 3'd5;

  localparam logic [2:0] REG_SCREEN_COLS    = 3'd0;
  localparam logic [2:0] REG_SCREEN_ROWS    = 3'd1;
  localparam logic [2:0] REG_CELL_WIDTH     = 3'd2;
  localparam logic [2:0] REG_CELL_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_BLINK_PERIOD   = 3'd4;
  localparam logic [2:0] REG_BLINK_ENABLE   = 3'd5;
  localparam logic [2:0] REG_CURSOR_VISIBLE = 3'd6;

  localparam logic [8:0]  RST_SCREEN_COLS  = 9'd80;
  localparam logic [7:0]  RST_SCREEN_ROWS  = 8'd25;
  localparam logic [7:0]  RST_CELL_WIDTH   = 8'd8;
  localparam logic [7:0]  RST_CELL_HEIGHT  = 8'd16;
  localparam logic [31:0] RST_BLINK_PERIOD = 32'd500;

  typedef struct packed {
    logic [8:0]  screen_cols;
    logic [7:0]  screen_rows;
    logic [7:0]  cell_width;
    logic [7:0]  cell_height;
    logic [31:0] blink_period;
    logic        blink_enable;
    logic        cursor_visible;
  } cfg_t;

  typedef struct packed {
    logic       old_vld;
    logic [7:0] old_col;
    logic [6:0] old_row;
    logic [7:0] col;
    logic [6:0] row;
    logic       blink;
  } job_t;

endpackage

/* src/tcmb_intf.sv */
`timescale 1ns / 1ps

interface tcmb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  dest_col;
  logic [6:0]  target_row;
  logic [7:0]  step;
  logic [31:0] now_ms;

  modport source (output valid, req_type, dest_col, target_row, step, now_ms,
                  input ready);
  modport sink (input valid, req_type, dest_col, target_row, step, now_ms,
                output ready);
endinterface

interface tcmb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  dirty_col;
  logic [6:0]  dirty_row;
  logic [7:0]  cursor_col_out;
  logic [6:0]  cursor_row_out;
  logic [15:0] pixel_x_out;
  logic [15:0] pixel_y_out;
  logic        blink_on;
  logic        last;

  modport source (output valid, dirty_col, dirty_row, cursor_col_out, cursor_row_out,
                  pixel_x_out, pixel_y_out, blink_on, last,
                  input ready);
  modport sink (input valid, dirty_col, dirty_row, cursor_col_out, cursor_row_out,
                pixel_x_out, pixel_y_out, blink_on, last,
                output ready);
endinterface

/* src/tcmb_front.sv */
`timescale 1ns / 1ps

module tcmb_front (
  input  logic          clk,
  input  logic          rst_n,
  tcmb_in_if.sink       in_if,
  input  tcmb_pkg::cfg_t cfg,
  input  logic          q_full,
  output logic          push,
  output tcmb_pkg::job_t push_job
);
  import tcmb_pkg::*;

  logic [7:0]  cur_col_r, cur_col_nxt;
  logic [6:0]  cur_row_r, cur_row_nxt;
  logic [7:0]  pref_col_r, pref_col_nxt;
  logic        blink_r, blink_nxt;
  logic [31:0] last_act_r, last_act_nxt;

  logic        acc;
  logic [8:0]  eff_cols;
  logic [7:0]  eff_rows;
  logic [7:0]  cmax;
  logic [6:0]  rmax;
  logic [7:0]  left_col;
  logic [8:0]  raw_col;
  logic [8:0]  raw_row;
  logic [7:0]  nc;
  logic [6:0]  nr;
  logic [7:0]  vert_col;
  logic        old_on;
  logic [31:0] elapsed;
  logic        due;

  assign in_if.ready = !q_full;
  assign acc         = in_if.valid && in_if.ready;

  always_comb begin
    eff_cols = cfg.screen_cols;
    if (eff_cols == 9'd0) eff_cols = 9'd1;
    if (eff_cols > 9'(COL_LIM)) eff_cols = 9'(COL_LIM);
    eff_rows = cfg.screen_rows;
    if (eff_rows == 8'd0) eff_rows = 8'd1;
    if (eff_rows > 8'(ROW_LIM)) eff_rows = 8'(ROW_LIM);
  end

  assign cmax = 8'(eff_cols - 9'd1);
  assign rmax = 7'(eff_rows - 8'd1);

  assign left_col = (cur_col_r >= in_if.step) ? cur_col_r - in_if.step : 8'd0;
  assign old_on   = (cur_col_r <= cmax) && (cur_row_r <= rmax);
  assign vert_col = (pref_col_r > cmax) ? cmax : pref_col_r;
  assign elapsed  = in_if.now_ms - last_act_r;
  assign due      = cfg.cursor_visible && cfg.blink_enable && (elapsed >= cfg.blink_period);

  always_comb begin
    case (in_if.req_type)
      REQ_MOVE_TO: raw_col = {1'b0, in_if.dest_col};
      REQ_LEFT:    raw_col = {1'b0, left_col};
      default:     raw_col = {1'b0, cur_col_r} + {1'b0, in_if.step};
    endcase
    case (in_if.req_type)
      REQ_MOVE_TO: raw_row = {2'b00, in_if.target_row};
      REQ_UP:      raw_row = ({1'b0, cur_row_r} >= in_if.step) ?
                             {2'b00, cur_row_r} - {1'b0, in_if.step} : 9'd0;
      REQ_DOWN:    raw_row = {2'b00, cur_row_r} + {1'b0, in_if.step};
      default:     raw_row = {2'b00, cur_row_r};
    endcase
  end

  assign nc = (raw_col > {1'b0, cmax}) ? cmax : raw_col[7:0];
  assign nr = (raw_row > {2'b00, rmax}) ? rmax : raw_row[6:0];

  always_comb begin
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    pref_col_nxt = pref_col_r;
    blink_nxt    = blink_r;
    last_act_nxt = last_act_r;
    push         = 1'b0;
    push_job     = '{old_vld: old_on, old_col: cur_col_r, old_row: cur_row_r,
                     col: nc, row: nr, blink: 1'b1};
    if (acc) begin
      unique case (in_if.req_type)
        REQ_MOVE_TO, REQ_LEFT, REQ_RIGHT: begin
          cur_col_nxt  = nc;
          cur_row_nxt  = nr;
          pref_col_nxt = nc;
          blink_nxt    = 1'b1;
          last_act_nxt = in_if.now_ms;
          push         = 1'b1;
        end
        REQ_UP, REQ_DOWN: begin
          cur_col_nxt  = vert_col;
          cur_row_nxt  = nr;
          blink_nxt    = 1'b1;
          last_act_nxt = in_if.now_ms;
          push         = 1'b1;
          push_job.col = vert_col;
        end
        REQ_TICK: begin
          if (due) begin
            blink_nxt    = ~blink_r;
            last_act_nxt = in_if.now_ms;
            push         = old_on;
            push_job     = '{old_vld: 1'b0, old_col: cur_col_r, old_row: cur_row_r,
                             col: cur_col_r, row: cur_row_r, blink: ~blink_r};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r  <= '0;
      cur_row_r  <= '0;
      pref_col_r <= '0;
      blink_r    <= 1'b1;
      last_act_r <= '0;
    end else begin
      cur_col_r  <= cur_col_nxt;
      cur_row_r  <= cur_row_nxt;
      pref_col_r <= pref_col_nxt;
      blink_r    <= blink_nxt;
      last_act_r <= last_act_nxt;
    end
  end

endmodule

/* src/tcmb_queue.sv */
`timescale 1ns / 1ps

module tcmb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcmb_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_vld,
  output tcmb_pkg::job_t head_job
);
  import tcmb_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* src/tcmb_back.sv */
`timescale 1ns / 1ps

module tcmb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tcmb_pkg::cfg_t cfg,
  input  logic           head_vld,
  input  tcmb_pkg::job_t head_job,
  output logic           pop,
  tcmb_out_if.source     out_if
);
  import tcmb_pkg::*;

  logic        half_r, half_nxt;
  logic        vld_r, vld_nxt;
  logic [7:0]  dirty_col_r;
  logic [6:0]  dirty_row_r;
  logic [7:0]  col_r;
  logic [6:0]  row_r;
  logic [15:0] px_r;
  logic [15:0] py_r;
  logic        blink_r;
  logic        last_r;

  logic        load;
  logic        first;

  assign load  = head_vld && (!vld_r || out_if.ready);
  assign first = head_job.old_vld && !half_r;
  assign pop   = load && !first;

  always_comb begin
    half_nxt = half_r;
    vld_nxt  = vld_r;
    if (load) begin
      half_nxt = first;
      vld_nxt  = 1'b1;
    end else if (out_if.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      half_r <= half_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dirty_col_r <= first ? head_job.old_col : head_job.col;
      dirty_row_r <= first ? head_job.old_row : head_job.row;
      col_r       <= head_job.col;
      row_r       <= head_job.row;
      px_r        <= {8'd0, head_job.col} * {8'd0, cfg.cell_width};
      py_r        <= {9'd0, head_job.row} * {8'd0, cfg.cell_height};
      blink_r     <= head_job.blink;
      last_r      <= !first;
    end
  end

  assign out_if.valid          = vld_r;
  assign out_if.dirty_col      = dirty_col_r;
  assign out_if.dirty_row      = dirty_row_r;
  assign out_if.cursor_col_out = col_r;
  assign out_if.cursor_row_out = row_r;
  assign out_if.pixel_x_out    = px_r;
  assign out_if.pixel_y_out    = py_r;
  assign out_if.blink_on       = blink_r;
  assign out_if.last           = last_r;

endmodule

/* src/text_cursor_motion_blink.sv */
`timescale 1ns / 1ps

// Text cursor controller. The front end takes one command per cycle while its two-entry job
// queue has room, updates the cursor, preferred column and blink timer at once, and queues
// one job per command that redraws anything. The back end turns a job into results through
// a single output register, one result per cycle while the output is not stalled: a move
// gives the old cell, then the new cell, or only the new cell when the old cell is off-screen;
// a tick gives at most one. A result passes from the job queue into the output register after
// its command is taken. Commands with no result (unknown codes, ticks that do not toggle or
// toggle an off-screen cursor) queue no job. Register writes on the APB port take effect at
// the edge that ends the access phase and read back at once.

module text_cursor_motion_blink (
  input  logic                              clk,
  input  logic                              rst_n,
  tcmb_in_if.sink                           in_if,
  tcmb_out_if.source                        out_if,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcmb_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import tcmb_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic       q_full;
  logic       push;
  job_t       push_job;
  logic       pop;
  logic       head_vld;
  job_t       head_job;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SCREEN_COLS:    cfg_nxt.screen_cols    = pwdata[8:0];
        REG_SCREEN_ROWS:    cfg_nxt.screen_rows    = pwdata[7:0];
        REG_CELL_WIDTH:     cfg_nxt.cell_width     = pwdata[7:0];
        REG_CELL_HEIGHT:    cfg_nxt.cell_height    = pwdata[7:0];
        REG_BLINK_PERIOD:   cfg_nxt.blink_period   = pwdata;
        REG_BLINK_ENABLE:   cfg_nxt.blink_enable   = pwdata[0];
        REG_CURSOR_VISIBLE: cfg_nxt.cursor_visible = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCREEN_COLS:    prdata = {23'd0, cfg_r.screen_cols};
      REG_SCREEN_ROWS:    prdata = {24'd0, cfg_r.screen_rows};
      REG_CELL_WIDTH:     prdata = {24'd0, cfg_r.cell_width};
      REG_CELL_HEIGHT:    prdata = {24'd0, cfg_r.cell_height};
      REG_BLINK_PERIOD:   prdata = cfg_r.blink_period;
      REG_BLINK_ENABLE:   prdata = {31'd0, cfg_r.blink_enable};
      REG_CURSOR_VISIBLE: prdata = {31'd0, cfg_r.cursor_visible};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{screen_cols: RST_SCREEN_COLS, screen_rows: RST_SCREEN_ROWS,
                 cell_width: RST_CELL_WIDTH, cell_height: RST_CELL_HEIGHT,
                 blink_period: RST_BLINK_PERIOD, blink_enable: 1'b1,
                 cursor_visible: 1'b1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcmb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  tcmb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head_vld (head_vld),
    .head_job (head_job)
  );

  tcmb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head_vld (head_vld),
    .head_job (head_job),
    .pop      (pop),
    .out_if   (out_if)
  );

endmodule

/* src/tcmb_checker.sv */
`timescale 1ns / 1ps

module tcmb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  dirty_col,
  input logic [6:0]  dirty_row,
  input logic [7:0]  cursor_col_out,
  input logic [6:0]  cursor_row_out,
  input logic        blink_on,
  input logic        last
);

  // stalled result holds valid, dirty cell, cursor column and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(dirty_col) && $stable(dirty_row)
      && $stable(cursor_col_out) && $stable(last))
    else $error("stalled result changed");

  // final result of a command redraws the cursor cell itself
  a_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last |-> dirty_col == cursor_col_out && dirty_row == cursor_row_out)
    else $error("final result does not redraw cursor cell");

  // old cell result only comes from a move, which restarts the phase
  a_move_blink: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> blink_on)
    else $error("old cell result with blink phase off");

  // old cell transfer is followed at once by the new cell
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last |=> out_valid && last
      && $stable(cursor_col_out) && $stable(cursor_row_out))
    else $error("new cell does not follow old cell");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind text_cursor_motion_blink tcmb_checker u_tcmb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .dirty_col      (out_if.dirty_col),
  .dirty_row      (out_if.dirty_row),
  .cursor_col_out (out_if.cursor_col_out),
  .cursor_row_out (out_if.cursor_row_out),
  .blink_on       (out_if.blink_on),
  .last           (out_if.last)
);
